### sv/tsp_pkg.sv
package tsp_pkg;

    localparam int X_W      = 16;
    localparam int X_FRAC   = 11;
    localparam int FRAC_W   = 24;
    localparam int MX_LSB   = FRAC_W - X_FRAC;
    localparam int SQ_FRAC  = 2 * X_FRAC;
    localparam int XSQ_W    = 31;
    localparam int MAG_W    = 46;
    localparam int HALF_W   = 23;
    localparam int PROD_W   = HALF_W + XSQ_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int DVD_W    = 56;
    localparam int DVS_W    = 12;
    localparam int DIGIT_W  = 8;
    localparam int DIV_STEPS = DVD_W / DIGIT_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);
    localparam int SUM_W    = 52;
    localparam int V_W      = 64;
    localparam int ROWF_W   = V_W - FRAC_W;
    localparam int ROW_W    = 16;
    localparam int NT_W     = 5;

    localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};
    localparam logic [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
    localparam logic [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_ACC,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_SCALE,
        ST_ROW
    } tsp_state_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic sqr;
        logic acc;
        logic mul_hi;
        logic mul_lo;
        logic div_start;
        logic mag_load;
        logic scale;
        logic row_load;
    } tsp_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic last_term;
        logic div_done;
        logic out_free;
    } tsp_status_t;

endpackage

### sv/tsp_div.sv
module tsp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tsp_pkg::DVD_W-1:0] dividend,
    input  logic [tsp_pkg::DVS_W-1:0] divisor,
    output logic [tsp_pkg::DVD_W-1:0] quotient,
    output logic                      done
);
    import tsp_pkg::*;

    localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(DIV_STEPS - 1);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVD_W-1:0]  quo_next;
    logic [DVS_W-1:0]  rem_next;
    logic [DVS_W:0]    trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < DIGIT_W; k++)
        begin
            trial    = {rem_next, quo_next[DVD_W-1]};
            quo_next = {quo_next[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### sv/tsp_ctrl.sv
module tsp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsp_pkg::tsp_status_t status,
    output tsp_pkg::tsp_ctrl_t   ctl
);
    import tsp_pkg::*;

    tsp_state_t state_reg;
    tsp_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (status.in_valid) state_next = ST_SQR;
            ST_SQR:      state_next = ST_ACC;
            ST_ACC:      state_next = status.last_term ? ST_SCALE : ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (status.div_done) state_next = ST_ACC;
            ST_SCALE:    state_next = ST_ROW;
            ST_ROW:      if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.ready     = (state_reg == ST_IDLE);
        ctl.load      = (state_reg == ST_IDLE) && status.in_valid;
        ctl.sqr       = (state_reg == ST_SQR);
        ctl.acc       = (state_reg == ST_ACC);
        ctl.mul_hi    = (state_reg == ST_MUL_HI);
        ctl.mul_lo    = (state_reg == ST_MUL_LO);
        ctl.div_start = (state_reg == ST_DIV_LOAD);
        ctl.mag_load  = (state_reg == ST_DIV_WAIT) && status.div_done;
        ctl.scale     = (state_reg == ST_SCALE);
        ctl.row_load  = (state_reg == ST_ROW) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/taylor_sine_plot_row_unit.sv
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+--------------------------
// in       | input     | in_valid / in_ready   | x_value[15:0] signed
// out      | output    | out_valid / out_ready | plot_row[15:0] signed, clipped
// cfg      | input     | cfg_we (no wait)      | cfg_data[4:0] = num_terms
//
// A word goes from acceptance via ST_SQR, ST_ACC, ST_SCALE and ST_ROW to its result and
// back to ST_IDLE for the next word; each term after the first costs two passes through
// the shared 23x31 multiplier and seven 8-bit digit steps of the constant divider.
// Reset sets num_terms to 1 and empties the output register.
// in_ready is high only while no word is in work; a held result stalls the final
// row load but not the acceptance of the word after it.
module taylor_sine_plot_row_unit #(
    parameter int MAX_TERMS     = 16,
    parameter int SCREEN_HEIGHT = 650
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsp_pkg::NT_W-1:0]         cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [tsp_pkg::X_W-1:0]   x_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [tsp_pkg::ROW_W-1:0] plot_row,
    output logic                             clipped
);
    import tsp_pkg::*;

    localparam int SCALE_K = SCREEN_HEIGHT / 20;
    localparam int OFFSET  = SCREEN_HEIGHT / 2;
    localparam int KW      = $clog2(SCALE_K + 1);
    localparam int PW      = SUM_W + KW + 1;

    tsp_ctrl_t   ctl;
    tsp_status_t status;

    logic [NT_W-1:0]          num_terms_reg;
    logic                     neg_reg;
    logic [XSQ_W-1:0]         xsq_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [NT_W-1:0]          idx_reg;
    logic [NT_W-1:0]          nm1_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [V_W-1:0]    v_reg;
    logic                     out_valid_reg;
    logic [ROW_W-1:0]         plot_row_reg;
    logic                     clipped_reg;

    logic [X_W-1:0]           x_raw;
    logic [X_W-1:0]           mx_in;
    logic [NT_W-1:0]          n_eff;
    logic [HALF_W-1:0]        mul_a;
    logic [XSQ_W-1:0]         mul_b;
    logic [PROD_W-1:0]        product;
    logic [NT_W:0]            d_even;
    logic [NT_W:0]            d_odd;
    logic [DVS_W-1:0]         d_value;
    logic [DVD_W-1:0]         quotient;
    logic                     div_done;
    logic signed [SUM_W-1:0]  mag_s;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [PW-1:0]     scaled;
    logic signed [V_W-1:0]    v_next;
    logic [V_W-1:0]           row_bias;
    logic [V_W-1:0]           row_sum;
    logic [ROWF_W-1:0]        row_full;
    logic [ROWF_W-ROW_W:0]    row_hi;
    logic [ROW_W-1:0]         row_sat;
    logic                     clip_next;
    logic                     out_free;

    tsp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    tsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend ({1'b0, acc_reg}),
        .divisor  (d_value),
        .quotient (quotient),
        .done     (div_done)
    );

    assign out_free         = !out_valid_reg || out_ready;
    assign status.in_valid  = in_valid;
    assign status.last_term = (idx_reg == nm1_reg);
    assign status.div_done  = div_done;
    assign status.out_free  = out_free;

    assign x_raw = x_value;
    assign mx_in = x_raw[X_W-1] ? X_W'(~x_raw + X_W'(1)) : x_raw;

    always_comb
    begin
        if (num_terms_reg == '0)
            n_eff = NT_W'(1);
        else if ({1'b0, num_terms_reg} > (NT_W+1)'(MAX_TERMS))
            n_eff = NT_W'(MAX_TERMS);
        else
            n_eff = num_terms_reg;
    end

    always_comb
    begin
        if (ctl.sqr)
            mul_a = HALF_W'(mag_reg[MX_LSB +: X_W]);
        else if (ctl.mul_hi)
            mul_a = mag_reg[MAG_W-1:HALF_W];
        else
            mul_a = mag_reg[HALF_W-1:0];
    end

    assign mul_b   = ctl.sqr ? XSQ_W'(mag_reg[MX_LSB +: X_W]) : xsq_reg;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign d_even  = {idx_reg, 1'b0};
    assign d_odd   = {idx_reg, 1'b1};
    assign d_value = DVS_W'(d_even) * DVS_W'(d_odd);

    assign mag_s    = SUM_W'(mag_reg);
    assign sum_next = (idx_reg[0] == neg_reg) ? sum_reg + mag_s : sum_reg - mag_s;

    assign scaled = PW'(sum_reg) * PW'($signed({1'b0, KW'(SCALE_K)}));
    assign v_next = {{(V_W-PW){scaled[PW-1]}}, scaled} + (V_W'(OFFSET) << FRAC_W);

    assign row_bias = v_reg[V_W-1] ? V_W'((64'd1 << FRAC_W) - 64'd1) : '0;
    assign row_sum  = v_reg + row_bias;
    assign row_full = row_sum[V_W-1:FRAC_W];
    assign row_hi   = row_full[ROWF_W-1:ROW_W-1];

    always_comb
    begin
        if ((&row_hi) || !(|row_hi))
        begin
            row_sat   = row_full[ROW_W-1:0];
            clip_next = 1'b0;
        end
        else
        begin
            row_sat   = row_full[ROWF_W-1] ? ROW_MIN : ROW_MAX;
            clip_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_terms_reg <= NT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                num_terms_reg <= cfg_data;
            if (ctl.row_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            neg_reg <= x_raw[X_W-1];
            mag_reg <= MAG_W'(mx_in) << MX_LSB;
            sum_reg <= '0;
            idx_reg <= '0;
            nm1_reg <= n_eff - NT_W'(1);
        end
        if (ctl.sqr)
            xsq_reg <= product[XSQ_W-1:0];
        if (ctl.mul_hi)
            acc_reg <= {product, 1'b0};
        if (ctl.mul_lo)
            acc_reg <= acc_reg + ACC_W'(product[PROD_W-1:SQ_FRAC]);
        if (ctl.mag_load)
            mag_reg <= (|quotient[DVD_W-1:MAG_W]) ? MAG_CAP : quotient[MAG_W-1:0];
        if (ctl.acc)
        begin
            sum_reg <= sum_next;
            if (!status.last_term)
                idx_reg <= idx_reg + NT_W'(1);
        end
        if (ctl.scale)
            v_reg <= v_next;
        if (ctl.row_load)
        begin
            plot_row_reg <= row_sat;
            clipped_reg  <= clip_next;
        end
    end

    assign in_ready  = ctl.ready;
    assign out_valid = out_valid_reg;
    assign plot_row  = plot_row_reg;
    assign clipped   = clipped_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after a word was accepted");

    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (plot_row == $signed(ROW_MAX) || plot_row == $signed(ROW_MIN)))
        else $error("clipped set on a row that is not at a limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.row_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");

endmodule

### tb/sv/taylor_sine_plot_row_checker.sv
module taylor_sine_plot_row_checker #(
    parameter int MAX_TERMS     = 16,
    parameter int SCREEN_HEIGHT = 650
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsp_pkg::NT_W-1:0]         cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic signed [tsp_pkg::X_W-1:0]   x_value,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [tsp_pkg::ROW_W-1:0] plot_row,
    input  logic                             clipped,
    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ROW_SCALE  = SCREEN_HEIGHT / 20;
    localparam longint ROW_OFFSET = longint'(SCREEN_HEIGHT / 2) <<< tsp_pkg::FRAC_W;
    localparam longint ONE_Q24    = longint'(1) <<< tsp_pkg::FRAC_W;
    localparam longint ROW_HI     = 32767;
    localparam longint ROW_LO     = -32768;

    typedef struct packed {
        logic signed [tsp_pkg::ROW_W-1:0] row;
        logic                             clip;
    } row_word_t;

    row_word_t               expected_rows[$];
    logic [tsp_pkg::NT_W-1:0] terms_reg = 5'd1;
    int                      fail_count = 0;

    assign mismatches = fail_count;

    function automatic row_word_t sine_row(input logic [tsp_pkg::X_W-1:0] x,
                                           input logic [tsp_pkg::NT_W-1:0] nt);
        logic         neg;
        logic [16:0]  mx;
        logic [30:0]  xsq;
        logic [63:0]  mag;
        logic [63:0]  quot;
        logic [63:0]  div;
        logic [127:0] prod;
        longint       sum;
        longint       v;
        longint       row;
        int           n;
        row_word_t    r;
        neg = x[tsp_pkg::X_W-1];
        mx  = neg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
        xsq = 31'(mx) * 31'(mx);
        mag = 64'(mx) << tsp_pkg::MX_LSB;
        n   = int'(nt);
        if (n < 1)
            n = 1;
        if (n > MAX_TERMS)
            n = MAX_TERMS;
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                div  = 64'((2 * i) * (2 * i + 1));
                prod = 128'(mag) * 128'(xsq);
                quot = 64'((prod >> tsp_pkg::SQ_FRAC) / 128'(div));
                mag  = (quot > 64'(tsp_pkg::MAG_CAP)) ? 64'(tsp_pkg::MAG_CAP) : quot;
            end
            if (i % 2 == 0)
                sum = sum + longint'(mag);
            else
                sum = sum - longint'(mag);
        end
        if (neg)
            sum = -sum;
        v   = sum * ROW_SCALE + ROW_OFFSET;
        row = v / ONE_Q24;
        r.clip = 1'b0;
        if (row > ROW_HI)
        begin
            row    = ROW_HI;
            r.clip = 1'b1;
        end
        else if (row < ROW_LO)
        begin
            row    = ROW_LO;
            r.clip = 1'b1;
        end
        r.row = row[tsp_pkg::ROW_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_word_t want;
        if (!rst_n)
        begin
            expected_rows.delete();
            terms_reg   <= 5'd1;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rows.size() == 0)
                    report_mismatch("word with nothing pending, plot_row", plot_row, 0);
                else
                begin
                    want = expected_rows.pop_front();
                    if (plot_row !== want.row)
                        report_mismatch("plot_row", plot_row, want.row);
                    if (clipped !== want.clip)
                        report_mismatch("clipped", int'(clipped), int'(want.clip));
                end
            end
            if (in_valid && in_ready)
                expected_rows.push_back(sine_row(x_value, terms_reg));
            if (cfg_we)
                terms_reg <= cfg_data;
            outstanding <= expected_rows.size();
        end
    end

endmodule

### tb/sv/tb_taylor_sine_plot_row_unit.sv
module tb_taylor_sine_plot_row_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TERMS     = 16;
    localparam int SCREEN_HEIGHT = 650;
    localparam int STALL_CYCLES  = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 200;
    localparam int CHUNKS        = 12;
    localparam int CHUNK_WORDS   = 100;

    localparam logic [tsp_pkg::X_W-1:0] X_TOP   = 16'sd20480;
    localparam logic [tsp_pkg::X_W-1:0] X_FLOOR = -16'sd20480;
    localparam logic [tsp_pkg::X_W-1:0] X_PMAX  = 16'h7FFF;
    localparam logic [tsp_pkg::X_W-1:0] X_NMAX  = 16'h8000;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [tsp_pkg::NT_W-1:0]         cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic signed [tsp_pkg::X_W-1:0]   x_value   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [tsp_pkg::ROW_W-1:0] plot_row;
    logic                             clipped;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    bit stall_ask     = 1'b0;
    bit stall_done    = 1'b0;

    logic [tsp_pkg::NT_W-1:0] edge_terms[4] = '{5'd1, 5'd16, 5'd0, 5'd31};

    always #5 clk = ~clk;

    taylor_sine_plot_row_unit #(
        .MAX_TERMS    (MAX_TERMS),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .x_value  (x_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .plot_row (plot_row),
        .clipped  (clipped)
    );

    taylor_sine_plot_row_checker #(
        .MAX_TERMS    (MAX_TERMS),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_value    (x_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .plot_row   (plot_row),
        .clipped    (clipped),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    function automatic logic [tsp_pkg::X_W-1:0] pick_x();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return 16'(int'($urandom_range(0, 40960)) - 20480);
        else if (sel < 85)
            return 16'($urandom);
        else if (sel < 93)
            return 16'(int'($urandom_range(0, 64)) - 32);
        else
        begin
            case ($urandom_range(0, 3))
                0:       return X_TOP;
                1:       return X_FLOOR;
                2:       return X_PMAX;
                default: return X_NMAX;
            endcase
        end
    endfunction

    task automatic send_word(input logic [tsp_pkg::X_W-1:0] x);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // hold until every predicted row has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_terms(input logic [tsp_pkg::NT_W-1:0] n);
        cfg_we   <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_ask && !stall_done)
            begin
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_done = 1'b1;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 36;
        recv_idle_pct = 65;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(16'h0000);
        send_word(X_TOP);
        send_word(X_FLOOR);
        drain();
        write_terms(5'd0);
        send_word(X_PMAX);
        send_word(X_NMAX);
        drain();
        write_terms(5'd3);
        send_word(X_PMAX);
        send_word(X_NMAX);
        send_word(X_TOP);
        drain();
        write_terms(5'd16);
        send_word(X_NMAX);
        send_word(X_PMAX);
        send_word(X_TOP);
        send_word(16'h0001);
        send_word(16'hFFFF);
        drain();
        write_terms(5'd31);
        send_word(X_NMAX);
        send_word(16'h5555);
        send_word(16'hAAAA);
        drain();
        write_terms(5'd7);
        send_word(16'sd6434);
        send_word(-16'sd6434);

        for (int c = 0; c < CHUNKS; c++)
        begin
            drain();
            if (c == 4)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 36;
            end
            else if (c == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_terms((c % 4 == 0 && c / 4 < 4) ? edge_terms[c / 4] :
                        (c < 4) ? edge_terms[c] : 5'($urandom_range(0, 31)));
            if (c == 1)
                stall_ask = 1'b1;
            repeat (CHUNK_WORDS) send_word(pick_x());
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
